FILE: sv/pas_pkg.sv
// Package for the peer authentication session table.
// Request, status, phase and counter codes, and stream field widths.
package pas_pkg;

  localparam int unsigned ReqW  = 4;
  localparam int unsigned NodeW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned NonceW = 64;
  localparam int unsigned SelW  = 4;
  localparam int unsigned CntW  = 32;
  localparam int unsigned ActW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 128;   // 122 bits of fields, padded
  localparam int unsigned OutDataW = 104;  // 99 bits of fields, padded

  localparam logic [ReqW-1:0] REQ_QUERY  = 4'd0;
  localparam logic [ReqW-1:0] REQ_CHAL   = 4'd1;
  localparam logic [ReqW-1:0] REQ_GOTCH  = 4'd2;
  localparam logic [ReqW-1:0] REQ_GOTRSP = 4'd3;
  localparam logic [ReqW-1:0] REQ_GOTCNF = 4'd4;
  localparam logic [ReqW-1:0] REQ_REVOKE = 4'd5;
  localparam logic [ReqW-1:0] REQ_SWEEP  = 4'd6;
  localparam logic [ReqW-1:0] REQ_INVAL  = 4'd7;
  localparam logic [ReqW-1:0] REQ_RDCNT  = 4'd8;
  localparam logic [ReqW-1:0] REQ_RSTCNT = 4'd9;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_VERIFY   = 2'd2;
  localparam logic [1:0] ST_SENDFAIL = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CHAL = 2'd1;
  localparam logic [1:0] PH_RESP = 2'd2;
  localparam logic [1:0] PH_AUTH = 2'd3;

  localparam logic [2:0] C_MISS   = 3'd0;
  localparam logic [2:0] C_HIT    = 3'd1;
  localparam logic [2:0] C_REAUTH = 3'd2;
  localparam logic [2:0] C_SENT   = 3'd3;
  localparam logic [2:0] C_RECV   = 3'd4;
  localparam logic [2:0] C_FAIL   = 3'd5;
  localparam logic [2:0] C_SUCC   = 3'd6;
  localparam logic [2:0] C_TMO    = 3'd7;

  localparam logic [SelW-1:0] SEL_ACTIVE = 4'd7;
  localparam logic [SelW-1:0] SEL_TMO    = 4'd8;

  localparam logic [CfgIdxW-1:0] CFG_LIFETIME = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HSTMO    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EPOCH    = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic              authenticated;
    logic [NonceW-1:0] held_nonce;
    logic [CntW-1:0]   counter_value;
  } result_t;

  // Shared age test: (now - t) mod 2^32 > limit
  function automatic logic aged(logic [TimeW-1:0] now, logic [TimeW-1:0] t,
                                logic [TimeW-1:0] limit);
    logic [TimeW-1:0] diff;
    diff = now - t;
    return diff > limit;
  endfunction

endpackage

FILE: sv/pas_stats.sv
// Statistics counters of the peer authentication session table.
// Uses pas_pkg; one increment, clear or read per cycle.
module pas_stats
  import pas_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            inc_i,
  input  logic [2:0]      inc_sel_i,
  input  logic [CntW-1:0] inc_amt_i,
  input  logic            clr_i,
  input  logic [2:0]      rd_sel_i,
  output logic [CntW-1:0] rd_data_o
);

  logic [CntW-1:0] cnt_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) cnt_q[k] <= '0;
    end else if (clr_i) begin
      for (int k = 0; k < 8; k++) cnt_q[k] <= '0;
    end else if (inc_i) begin
      cnt_q[inc_sel_i] <= cnt_q[inc_sel_i] + inc_amt_i;
    end
  end

  assign rd_data_o = cnt_q[rd_sel_i];

endmodule

FILE: sv/peer_auth_session_table_top.sv
// Top level of the peer authentication session table.
// Uses pas_pkg and pas_stats; entry table in flops scanned by one sequencer.
//
//  channel  | dir | beat fields (low bit up)
//  s_axis   | in  | req_type, node_id, now, mac_ok, nonce, send_ok, counter_select
//  m_axis   | out | status, authenticated, held_nonce, counter_value
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (no handshake)
//
// After the accept, table requests scan the entries one per cycle through a shared
// compare unit, then an update state and a result state; allocation adds a scan for
// a free, aged or oldest entry. Sweep skips the update, invalidate clears every
// entry first, counter requests skip the scan. Reset empties the table at once.
// s_axis_tready is low from accept until the result beat is taken.
module peer_auth_session_table_top
  import pas_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // req_type[3:0], node_id[19:4], now[51:20], mac_ok[52], nonce[116:53],
  // send_ok[117], counter_select[121:118]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[1:0], authenticated[2], held_nonce[66:3], counter_value[98:67]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TimeW-1:0]    cfg_data_i
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CtrW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CtrW-1:0] LastCtr = CtrW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_ALLOC, S_ACT, S_SWEEP, S_INVAL, S_OUT
  } state_e;

  state_e state_q;
  logic [TimeW-1:0] life_q, hstmo_q, epoch_q;

  logic [NodeW-1:0]  node_q  [TABLE_DEPTH];
  logic [1:0]        phase_q [TABLE_DEPTH];
  logic [TimeW-1:0]  time_q  [TABLE_DEPTH];
  logic [TimeW-1:0]  ep_q    [TABLE_DEPTH];
  logic [NonceW-1:0] nonce_q [TABLE_DEPTH];
  logic [ActW-1:0]   active_q;

  logic [ReqW-1:0]   req_q;
  logic [NodeW-1:0]  id_q;
  logic [TimeW-1:0]  now_q;
  logic              mac_q, send_q;
  logic [NonceW-1:0] nin_q;
  logic [SelW-1:0]   sel_q;

  logic [CtrW-1:0] ctr_q;
  logic [IdxW-1:0] hit_q, best_q;
  logic            found_q;
  result_t         res_q;

  logic [IdxW-1:0] ci;
  logic [IdxW-1:0] cmp_idx;
  logic            c_aged;
  logic [TimeW-1:0] c_limit;
  logic            st_inc, st_clr;
  logic [2:0]      st_sel;
  logic [2:0]      rd_sel;
  logic [CntW-1:0] st_amt, st_rd;

  assign ci = ctr_q[IdxW-1:0];
  always_comb begin
    c_limit = life_q;
    if (state_q == S_SWEEP && (phase_q[ci] == PH_CHAL || phase_q[ci] == PH_RESP))
      c_limit = hstmo_q;
  end
  // the shared compare unit; the update cycle checks the matched entry
  assign cmp_idx = (state_q == S_ACT) ? hit_q : ci;
  assign c_aged = aged(now_q, time_q[cmp_idx], c_limit);

  // select 8 is the timeout counter, kept in the last slot
  assign rd_sel = (sel_q == SEL_TMO) ? C_TMO : sel_q[2:0];

  pas_stats u_stats (
    .clk_i, .rst_ni,
    .inc_i(st_inc), .inc_sel_i(st_sel), .inc_amt_i(st_amt),
    .clr_i(st_clr), .rd_sel_i(rd_sel), .rd_data_o(st_rd)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {5'd0, res_q.counter_value, res_q.held_nonce,
                          res_q.authenticated, res_q.status};

  // counter events, decided combinationally from the sequencer state
  always_comb begin
    st_inc = 1'b0;
    st_sel = C_MISS;
    st_amt = CntW'(1);
    st_clr = 1'b0;
    unique case (state_q)
      S_ACT: begin
        unique case (req_q)
          REQ_QUERY: begin
            st_inc = 1'b1;
            if (!found_q || c_aged) st_sel = C_MISS;
            else if (ep_q[hit_q] != epoch_q) st_sel = C_REAUTH;
            else if (phase_q[hit_q] == PH_AUTH) st_sel = C_HIT;
            else st_inc = 1'b0;
          end
          REQ_CHAL: begin
            st_inc = send_q && (id_q != '0);
            st_sel = C_SENT;
          end
          REQ_GOTCH: begin
            st_inc = (id_q != '0);
            st_sel = C_RECV;
          end
          REQ_GOTRSP, REQ_GOTCNF: begin
            st_inc = 1'b1;
            if (found_q && mac_q && phase_q[hit_q] ==
                ((req_q == REQ_GOTRSP) ? PH_CHAL : PH_RESP)) st_sel = C_SUCC;
            else st_sel = C_FAIL;
          end
          REQ_INVAL: begin
            st_inc = 1'b1;
            st_sel = C_REAUTH;
            st_amt = CntW'(TABLE_DEPTH);
          end
          REQ_RSTCNT: st_clr = 1'b1;
          default: ;
        endcase
      end
      S_SWEEP: begin
        st_sel = C_TMO;
        st_inc = (node_q[ci] != '0) && (phase_q[ci] == PH_CHAL ||
                 phase_q[ci] == PH_RESP) && c_aged;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      life_q   <= 32'd60000;
      hstmo_q  <= 32'd5000;
      epoch_q  <= '0;
      active_q <= '0;
      ctr_q    <= '0;
      found_q  <= 1'b0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        node_q[k]  <= '0;
        phase_q[k] <= PH_IDLE;
        time_q[k]  <= '0;
        ep_q[k]    <= '0;
        nonce_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LIFETIME: life_q  <= cfg_data_i;
          CFG_HSTMO:    hstmo_q <= cfg_data_i;
          CFG_EPOCH:    epoch_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_q   <= s_axis_tdata[3:0];
            id_q    <= s_axis_tdata[19:4];
            now_q   <= s_axis_tdata[51:20];
            mac_q   <= s_axis_tdata[52];
            nin_q   <= s_axis_tdata[116:53];
            send_q  <= s_axis_tdata[117];
            sel_q   <= s_axis_tdata[121:118];
            ctr_q   <= '0;
            found_q <= 1'b0;
            res_q   <= '0;
            priority case (s_axis_tdata[3:0])
              REQ_QUERY, REQ_CHAL, REQ_GOTCH, REQ_GOTRSP, REQ_GOTCNF, REQ_REVOKE:
                state_q <= S_LOOK;
              REQ_SWEEP: state_q <= S_SWEEP;
              REQ_INVAL: state_q <= S_INVAL;
              default:   state_q <= S_ACT;
            endcase
          end
        end
        S_LOOK: begin
          if (!found_q && id_q != '0 && node_q[ci] == id_q) begin
            found_q <= 1'b1;
            hit_q   <= ci;
          end
          if (ctr_q == LastCtr) begin
            ctr_q  <= '0;
            best_q <= '0;
            if ((req_q == REQ_CHAL || req_q == REQ_GOTCH) && id_q != '0 && !found_q &&
                !(node_q[ci] == id_q))
              state_q <= S_ALLOC;
            else
              state_q <= S_ACT;
          end else begin
            ctr_q <= ctr_q + CtrW'(1);
          end
        end
        S_ALLOC: begin
          if (node_q[ci] == '0 || c_aged) begin
            hit_q   <= ci;
            found_q <= 1'b1;
            state_q <= S_ACT;
          end else if (ctr_q == LastCtr) begin
            hit_q   <= (time_q[ci] < time_q[best_q]) ? ci : best_q;
            found_q <= 1'b1;
            state_q <= S_ACT;
          end else begin
            if (time_q[ci] < time_q[best_q]) best_q <= ci;
            ctr_q <= ctr_q + CtrW'(1);
          end
        end
        S_ACT: begin
          state_q <= S_OUT;
          unique case (req_q)
            REQ_QUERY: begin
              if (!found_q) res_q.status <= ST_NOTFOUND;
              else if (c_aged || ep_q[hit_q] != epoch_q) begin
                res_q.status    <= ST_NOTFOUND;
                node_q[hit_q]  <= '0;
                phase_q[hit_q] <= PH_IDLE;
                time_q[hit_q]  <= '0;
                ep_q[hit_q]    <= '0;
                nonce_q[hit_q] <= '0;
              end else begin
                res_q.held_nonce    <= nonce_q[hit_q];
                res_q.authenticated <= (phase_q[hit_q] == PH_AUTH);
              end
            end
            REQ_CHAL, REQ_GOTCH: begin
              if (id_q == '0) res_q.status <= ST_NOTFOUND;
              else begin
                node_q[hit_q]  <= id_q;
                phase_q[hit_q] <= (req_q == REQ_CHAL) ? PH_CHAL : PH_RESP;
                time_q[hit_q]  <= now_q;
                ep_q[hit_q]    <= epoch_q;
                nonce_q[hit_q] <= nin_q;
                res_q.held_nonce <= nin_q;
                if (!send_q) res_q.status <= ST_SENDFAIL;
              end
            end
            REQ_GOTRSP, REQ_GOTCNF: begin
              if (!found_q || phase_q[hit_q] !=
                  ((req_q == REQ_GOTRSP) ? PH_CHAL : PH_RESP))
                res_q.status <= ST_NOTFOUND;
              else if (!mac_q) begin
                res_q.status   <= ST_VERIFY;
                node_q[hit_q]  <= '0;
                phase_q[hit_q] <= PH_IDLE;
                time_q[hit_q]  <= '0;
                ep_q[hit_q]    <= '0;
                nonce_q[hit_q] <= '0;
              end else begin
                phase_q[hit_q] <= PH_AUTH;
                time_q[hit_q]  <= now_q;
                active_q       <= active_q + ActW'(1);
                res_q.held_nonce <= nonce_q[hit_q];
                if (req_q == REQ_GOTRSP && !send_q) res_q.status <= ST_SENDFAIL;
              end
            end
            REQ_REVOKE: begin
              if (!found_q) res_q.status <= ST_NOTFOUND;
              else begin
                if (phase_q[hit_q] == PH_AUTH) active_q <= active_q - ActW'(1);
                node_q[hit_q]  <= '0;
                phase_q[hit_q] <= PH_IDLE;
                time_q[hit_q]  <= '0;
                ep_q[hit_q]    <= '0;
                nonce_q[hit_q] <= '0;
              end
            end
            REQ_RDCNT: begin
              if (sel_q <= SEL_ACTIVE - 4'd1) res_q.counter_value <= st_rd;
              else if (sel_q == SEL_ACTIVE) res_q.counter_value <= CntW'(active_q);
              else if (sel_q == SEL_TMO) res_q.counter_value <= st_rd;
            end
            default: ;
          endcase
        end
        S_SWEEP: begin
          if (node_q[ci] != '0 && phase_q[ci] != PH_IDLE && c_aged) begin
            if (phase_q[ci] == PH_AUTH) active_q <= active_q - ActW'(1);
            node_q[ci]  <= '0;
            phase_q[ci] <= PH_IDLE;
            time_q[ci]  <= '0;
            ep_q[ci]    <= '0;
            nonce_q[ci] <= '0;
          end
          if (ctr_q == LastCtr) state_q <= S_OUT;
          else ctr_q <= ctr_q + CtrW'(1);
        end
        S_INVAL: begin
          if (phase_q[ci] == PH_AUTH) active_q <= active_q - ActW'(1);
          node_q[ci]  <= '0;
          phase_q[ci] <= PH_IDLE;
          time_q[ci]  <= '0;
          ep_q[ci]    <= '0;
          nonce_q[ci] <= '0;
          if (ctr_q == LastCtr) state_q <= S_ACT;
          else ctr_q <= ctr_q + CtrW'(1);
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");
  a_scan_ctr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK || state_q == S_SWEEP) |-> ctr_q <= LastCtr)
    else $error("scan index out of range");
`endif

endmodule
